// File: hdl/complex_number_alu_unit_assert.svh
// Assertion macros for the complex number ALU.
`ifndef COMPLEX_NUMBER_ALU_UNIT_ASSERT_SVH
`define COMPLEX_NUMBER_ALU_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CNA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CNA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CNA_ASSERT_IMP(label, clk, rst, ante, cons)
`define CNA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/cna_pkg.sv
package cna_pkg;
   localparam int NUM_VARS_DEF  = 6;
   localparam int FRAC_BITS_DEF = 16;

   typedef enum logic [2:0] {
      OP_LOAD = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2, OP_SCALE_RE = 3'd3,
      OP_SCALE_IM = 3'd4, OP_CMUL = 3'd5, OP_MAG = 3'd6, OP_OUT = 3'd7
   } op_type;

   // Classified item passed from the front part to the back part.
   typedef struct packed {
      op_type      op;
      logic [31:0] ar;
      logic [31:0] ai;
      logic [31:0] br;
      logic [31:0] bi;
      logic [31:0] k;
   } work_type;

   typedef struct packed {
      logic [31:0] result_real;
      logic [31:0] result_img;
      logic        is_magnitude;
      logic        saturated;
   } rsp_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic [32:0] clamp32(input logic signed [65:0] x);
      logic [32:0] r;
      if (x > 66'sd2147483647) r = {1'b1, 32'h7FFF_FFFF};
      else if (x < -66'sd2147483648) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, x[31:0]};
      return r;
   endfunction
endpackage

// File: hdl/cna_if.sv
interface cna_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [2:0]  first_var;
   logic [2:0]  second_var;
   logic [31:0] value_real;
   logic [31:0] value_img;
   modport source (output valid, opcode, first_var, second_var, value_real, value_img,
                   input ready);
   modport sink (input valid, opcode, first_var, second_var, value_real, value_img,
                 output ready);
endinterface

interface cna_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_real;
   logic [31:0] result_img;
   logic        is_magnitude;
   logic        saturated;
   modport source (output valid, result_real, result_img, is_magnitude, saturated,
                   input ready);
   modport sink (input valid, result_real, result_img, is_magnitude, saturated,
                 output ready);
endinterface

// File: hdl/cna_front.sv
`include "complex_number_alu_unit_assert.svh"
module cna_front #(
   parameter int NUM_VARS = cna_pkg::NUM_VARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   cna_req_if.sink           req,
   output logic              q_valid,
   input  logic              q_ready,
   output cna_pkg::work_type q_data
);
   localparam int IW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

   logic [31:0] re_ff [NUM_VARS];
   logic [31:0] im_ff [NUM_VARS];
   logic        valid_ff, valid_in;
   cna_pkg::work_type data_ff, data_in;
   logic        take;
   logic        a_ok, b_ok;

   // One-entry queue slot toward the back part.
   assign req.ready = !valid_ff || q_ready;
   assign take      = req.valid && req.ready;
   assign q_valid   = valid_ff;
   assign q_data    = data_ff;
   assign a_ok      = 32'(req.first_var) < 32'(NUM_VARS);
   assign b_ok      = 32'(req.second_var) < 32'(NUM_VARS);

   // Fetch operands; out-of-range indices read as zero.
   always_comb begin
      data_in    = data_ff;
      data_in.op = cna_pkg::op_type'(req.opcode);
      data_in.ar = a_ok ? re_ff[req.first_var[IW-1:0]] : '0;
      data_in.ai = a_ok ? im_ff[req.first_var[IW-1:0]] : '0;
      data_in.br = b_ok ? re_ff[req.second_var[IW-1:0]] : '0;
      data_in.bi = b_ok ? im_ff[req.second_var[IW-1:0]] : '0;
      data_in.k  = req.value_real;
      valid_in   = valid_ff;
      if (q_ready) valid_in = 1'b0;
      if (take && cna_pkg::op_type'(req.opcode) != cna_pkg::OP_LOAD) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < NUM_VARS; i++) begin
            re_ff[i] <= '0;
            im_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         if (take && cna_pkg::op_type'(req.opcode) == cna_pkg::OP_LOAD && a_ok) begin
            re_ff[req.first_var[IW-1:0]] <= req.value_real;
            im_ff[req.first_var[IW-1:0]] <= req.value_img;
         end
      end
      if (take) data_ff <= data_in;
   end

   `CNA_ASSERT_NXT(a_hold, clock, reset, valid_ff && !q_ready, valid_ff && $stable(data_ff))
   `CNA_ASSERT_NXT(a_load_none, clock, reset,
      take && req.opcode == cna_pkg::OP_LOAD && !(valid_ff && !q_ready), !valid_ff)
   `CNA_ASSERT_IMP(a_rdy, clock, reset, !valid_ff, req.ready)
endmodule

// File: hdl/cna_back.sv
`include "complex_number_alu_unit_assert.svh"
module cna_back #(
   parameter int FRAC_BITS = cna_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  cna_pkg::work_type q_data,
   cna_rsp_if.source         rsp
);
   typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_SQRT, S_DONE} state_type;

   state_type   state_ff;
   cna_pkg::work_type w_ff;
   logic [1:0]  step_ff;
   logic signed [63:0] p_ff [4];
   logic [5:0]  cnt_ff;
   logic [63:0] rem_ff, root_ff, v_ff;
   cna_pkg::rsp_type out_ff;

   logic signed [31:0] mx, my;
   logic signed [63:0] prod;
   logic [63:0] trial;
   logic [32:0] c0, c1;
   logic signed [65:0] s0, s1;

   assign q_ready = (state_ff == S_IDLE);
   assign rsp.valid        = (state_ff == S_DONE);
   assign rsp.result_real  = out_ff.result_real;
   assign rsp.result_img   = out_ff.result_img;
   assign rsp.is_magnitude = out_ff.is_magnitude;
   assign rsp.saturated    = out_ff.saturated;

   // Shared multiplier: one product per cycle in the order ar*x, ai*y, ar*bi, ai*br.
   always_comb begin
      mx = signed'(w_ff.ar);
      my = signed'(w_ff.k);
      case (step_ff)
         2'd0: begin
            mx = signed'(w_ff.ar);
            my = (w_ff.op == cna_pkg::OP_CMUL) ? signed'(w_ff.br) :
                 (w_ff.op == cna_pkg::OP_MAG) ? signed'(w_ff.ar) : signed'(w_ff.k);
         end
         2'd1: begin
            mx = signed'(w_ff.ai);
            my = (w_ff.op == cna_pkg::OP_CMUL) ? signed'(w_ff.bi) :
                 (w_ff.op == cna_pkg::OP_MAG) ? signed'(w_ff.ai) : signed'(w_ff.k);
         end
         2'd2: begin
            mx = signed'(w_ff.ar);
            my = signed'(w_ff.bi);
         end
         default: begin
            mx = signed'(w_ff.ai);
            my = signed'(w_ff.br);
         end
      endcase
      prod  = mx * my;
      trial = root_ff + v_ff;
   end

   // Finish add, sub and output from operands, scale and multiply from products.
   always_comb begin
      s0 = '0;
      s1 = '0;
      case (w_ff.op)
         cna_pkg::OP_ADD: begin
            s0 = 66'(signed'(w_ff.ar)) + 66'(signed'(w_ff.br));
            s1 = 66'(signed'(w_ff.ai)) + 66'(signed'(w_ff.bi));
         end
         cna_pkg::OP_SUB: begin
            s0 = 66'(signed'(w_ff.ar)) - 66'(signed'(w_ff.br));
            s1 = 66'(signed'(w_ff.ai)) - 66'(signed'(w_ff.bi));
         end
         cna_pkg::OP_SCALE_RE: begin
            s0 = 66'(p_ff[0]) >>> FRAC_BITS;
            s1 = 66'(p_ff[1]) >>> FRAC_BITS;
         end
         cna_pkg::OP_SCALE_IM: begin
            s0 = (-66'(p_ff[1])) >>> FRAC_BITS;
            s1 = 66'(p_ff[0]) >>> FRAC_BITS;
         end
         cna_pkg::OP_CMUL: begin
            s0 = (66'(p_ff[0]) - 66'(p_ff[1])) >>> FRAC_BITS;
            s1 = (66'(p_ff[2]) + 66'(p_ff[3])) >>> FRAC_BITS;
         end
         default: begin
            s0 = 66'(signed'(w_ff.ar));
            s1 = 66'(signed'(w_ff.ai));
         end
      endcase
      c0 = cna_pkg::clamp32(s0);
      c1 = cna_pkg::clamp32(s1);
   end

   // Sequencer: any multiply steps, then either a sum or a 32-step square root.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: if (q_valid) begin
               w_ff    <= q_data;
               step_ff <= '0;
               if (q_data.op == cna_pkg::OP_ADD || q_data.op == cna_pkg::OP_SUB ||
                   q_data.op == cna_pkg::OP_OUT) state_ff <= S_SUM;
               else state_ff <= S_MUL;
            end
            S_MUL: begin
               p_ff[step_ff] <= prod;
               step_ff <= step_ff + 2'd1;
               if ((w_ff.op == cna_pkg::OP_CMUL && step_ff == 2'd3) ||
                   (w_ff.op != cna_pkg::OP_CMUL && step_ff == 2'd1)) begin
                  if (w_ff.op == cna_pkg::OP_MAG) begin
                     state_ff <= S_SQRT;
                     rem_ff   <= 64'(p_ff[0]) + 64'(prod);
                     root_ff  <= '0;
                     v_ff     <= 64'h4000_0000_0000_0000;
                     cnt_ff   <= '0;
                  end else begin
                     state_ff <= S_SUM;
                  end
               end
            end
            S_SUM: begin
               out_ff.result_real  <= c0[31:0];
               out_ff.result_img   <= c1[31:0];
               out_ff.is_magnitude <= 1'b0;
               out_ff.saturated    <= (w_ff.op != cna_pkg::OP_OUT) && (c0[32] || c1[32]);
               state_ff <= S_DONE;
            end
            S_SQRT: begin
               if (rem_ff >= trial) begin
                  rem_ff  <= rem_ff - trial;
                  root_ff <= (root_ff >> 1) + v_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               v_ff   <= v_ff >> 2;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  state_ff <= S_DONE;
                  out_ff.result_img   <= '0;
                  out_ff.is_magnitude <= 1'b1;
                  if (rem_ff >= trial) begin
                     out_ff.saturated   <= ((root_ff >> 1) + v_ff) > 64'h7FFF_FFFF;
                     out_ff.result_real <= (((root_ff >> 1) + v_ff) > 64'h7FFF_FFFF) ?
                        32'h7FFF_FFFF : 32'((root_ff >> 1) + v_ff);
                  end else begin
                     out_ff.saturated   <= (root_ff >> 1) > 64'h7FFF_FFFF;
                     out_ff.result_real <= ((root_ff >> 1) > 64'h7FFF_FFFF) ?
                        32'h7FFF_FFFF : 32'(root_ff >> 1);
                  end
               end
            end
            S_DONE: if (rsp.ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `CNA_ASSERT_NXT(b_hold, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(out_ff))
   `CNA_ASSERT_IMP(b_mag_img, clock, reset, rsp.valid && rsp.is_magnitude,
      rsp.result_img == 32'd0)
   `CNA_ASSERT_NXT(b_sqrt_end, clock, reset, state_ff == S_SQRT && cnt_ff == 6'd31,
      state_ff == S_DONE && rsp.is_magnitude)
endmodule

// File: hdl/complex_number_alu_unit.sv
// Complex number ALU over a file of NUM_VARS complex variables in signed fixed
// point with FRAC_BITS fraction bits. The req channel carries one command beat
// (opcode, two variable indices, two operand words); the rsp channel returns
// one result beat for every opcode but load. Both use valid/ready.
// The front part reads operands from the register file and performs loads at
// once, then parks each other command in a one-entry queue. The back part runs
// it in a sequencer: add, sub and output go straight to the sum step, scale and
// complex multiply first take their products from one shared 32x32 multiplier,
// and magnitude takes 2 multiplies then a 32-step bit-serial square root. A new
// command may follow when the back part returns to idle after its result is
// taken. The front can hold one more command and take loads while the queue
// slot is free. A stalled result holds steady until rsp.ready. Reset clears
// the variable file to zero and empties the queue and the back part.
module complex_number_alu_unit #(
   parameter int NUM_VARS  = cna_pkg::NUM_VARS_DEF,
   parameter int FRAC_BITS = cna_pkg::FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   cna_req_if.sink   req,
   cna_rsp_if.source rsp
);
   logic              q_valid, q_ready;
   cna_pkg::work_type q_data;

   cna_front #(.NUM_VARS(NUM_VARS)) u_front (
      .clock, .reset, .req, .q_valid, .q_ready, .q_data
   );

   cna_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data, .rsp
   );
endmodule
